// File: hw/rtl/msss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msss_pkg: shared types and constants for the multi-stack shared store
// Field structs, status codes and pointer widths used by every module.
// ----------------------------------------------------------------------------
package msss_pkg;

  localparam int STACKS = 4;
  localparam int DEPTH  = 256;

  // An entry index, and a pointer that can also hold the null value DEPTH.
  localparam int IDX_W = $clog2(DEPTH);
  localparam int PTR_W = $clog2(DEPTH + 1);
  localparam int SID_W = 2;

  localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(DEPTH);

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic               action;
    logic [SID_W-1:0]   stack_id;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_value;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // latch the request and read the memories
    logic commit;     // apply the pointer and memory updates
    logic hold;       // park the result while the output is occupied
    logic emit_now;   // load the live result into the output register
    logic emit_held;  // load the parked result into the output register
  } cmd_t;

endpackage

// File: hw/rtl/msss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msss_ctrl: request sequencer
// Accepts one transaction, steps it through read and update, and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module msss_ctrl
  import msss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_POST
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   room;

  // The output register can take a result if it is empty or draining now.
  assign room = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_READ;
        end
      end
      S_READ: begin
        cmd_o.commit = 1'b1;
        if (room) begin
          cmd_o.emit_now = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.hold = 1'b1;
          state_d    = S_POST;
        end
      end
      S_POST: begin
        if (room) begin
          cmd_o.emit_held = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/msss_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msss_dp: pointer registers, link and value memories, result registers
// Holds the stack tops, the free list head and the shared entry store.
// ----------------------------------------------------------------------------
module msss_dp
  import msss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  req_t in_data_i,
  output res_t out_data_o
);

  logic [PTR_W-1:0]   stack_top_q [STACKS];
  logic [PTR_W-1:0]   free_head_q;
  logic [DEPTH-1:0]   link_valid_q;

  logic [PTR_W-1:0]   link_mem  [DEPTH];
  logic [31:0]        value_mem [DEPTH];

  req_t               req_q;
  logic               refused_q;
  logic [IDX_W-1:0]   slot_q;
  logic [PTR_W-1:0]   link_rd_q;
  logic [31:0]        value_rd_q;
  logic               link_ok_q;

  logic [PTR_W-1:0]   slot_sel;
  logic               refused_d;
  logic [PTR_W-1:0]   link_now;
  logic               do_update;
  res_t               res_now;
  res_t               res_held_q;
  res_t               out_q;

  // A push takes the free list head, a pop takes the chosen stack's top.
  assign slot_sel  = (in_data_i.action == ACT_POP) ? stack_top_q[in_data_i.stack_id]
                                                   : free_head_q;
  assign refused_d = (32'(in_data_i.stack_id) >= STACKS) || (slot_sel >= PTR_NULL);

  // Links never written read as their reset chain value, the slot plus one.
  assign link_now  = link_ok_q ? link_rd_q : (PTR_W'(slot_q) + PTR_W'(1));
  assign do_update = cmd_i.commit && !refused_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q      <= in_data_i;
      refused_q  <= refused_d;
      slot_q     <= slot_sel[IDX_W-1:0];
      link_rd_q  <= link_mem[slot_sel[IDX_W-1:0]];
      value_rd_q <= value_mem[slot_sel[IDX_W-1:0]];
    end
    if (do_update) begin
      if (req_q.action == ACT_PUSH) begin
        link_mem[slot_q]  <= stack_top_q[req_q.stack_id];
        value_mem[slot_q] <= req_q.value;
      end else begin
        link_mem[slot_q]  <= free_head_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_ok_q    <= 1'b0;
      link_valid_q <= '0;
      free_head_q  <= '0;
      for (int i = 0; i < STACKS; i++) begin
        stack_top_q[i] <= PTR_NULL;
      end
    end else begin
      if (cmd_i.accept) begin
        link_ok_q <= link_valid_q[slot_sel[IDX_W-1:0]];
      end
      if (do_update) begin
        link_valid_q[slot_q] <= 1'b1;
        if (req_q.action == ACT_PUSH) begin
          free_head_q                  <= link_now;
          stack_top_q[req_q.stack_id]  <= PTR_W'(slot_q);
        end else begin
          stack_top_q[req_q.stack_id]  <= link_now;
          free_head_q                  <= PTR_W'(slot_q);
        end
      end
    end
  end

  always_comb begin
    res_now.popped_value = '1;
    if (refused_q) begin
      res_now.status = (req_q.action == ACT_PUSH) ? STATUS_FULL : STATUS_EMPTY;
    end else begin
      res_now.status = STATUS_DONE;
      if (req_q.action == ACT_POP) begin
        res_now.popped_value = value_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold) begin
      res_held_q <= res_now;
    end
    if (cmd_i.emit_now) begin
      out_q <= res_now;
    end else if (cmd_i.emit_held) begin
      out_q <= res_held_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// File: hw/rtl/multi_stack_shared_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_stack_shared_store: several stacks linked through one entry store
// Push and pop requests on a chosen stack, with a shared free list.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  request   in_valid_i / in_ready_o    in_data_i  (action, stack_id, value)
//  result    out_valid_o / out_ready_i  out_data_o (status, popped_value)
//
//  Each transaction has a read step, which selects the top or free pointer
//  and reads the link and value memories, then an update that writes the links back.
//  A result waiting in the output register delays the next acceptance only
//  once the following result is ready and still has nowhere to go.
//  Reset is immediate: link valid bits stand in for the initial free chain.
// ----------------------------------------------------------------------------
module multi_stack_shared_store
  import msss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  cmd_t cmd;

  msss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  msss_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  // Only one transaction is in flight, so no request follows straight on.
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // With an empty output, a result leaves the read state straight for the output.
  a_result_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !out_valid_o) |-> ##2 out_valid_o)
    else $error("result not delivered on time");

  a_cmd_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.commit, cmd.emit_held}))
    else $error("conflicting datapath commands");

endmodule

// File: tb/sv/msss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msss_checker: result predictor and scoreboard for multi_stack_shared_store
// Keeps its own copy of the stack tops, free list and entry store, works out
// the answer to every accepted request and compares it with each result.
// ----------------------------------------------------------------------------
module msss_checker
  import msss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  req_t in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  res_t out_data_i,
  output int   fail_count_o,
  output int   pending_o
);

  logic signed [31:0] entry_word [DEPTH];
  logic [PTR_W-1:0]   entry_next [DEPTH];
  logic [PTR_W-1:0]   top_of [STACKS];
  logic [PTR_W-1:0]   free_ptr;

  res_t awaited_results [$];
  res_t oldest;
  int   fails;

  // Applies one request to the shadow stacks and returns the answer it earns.
  // Any pointer at or beyond DEPTH counts as null.
  function automatic res_t serve_request(req_t r);
    res_t             res;
    logic [PTR_W-1:0] slot;
    int               sid;
    res.status       = STATUS_DONE;
    res.popped_value = '1;
    sid              = int'(r.stack_id);
    if (r.action == ACT_PUSH) begin
      if (sid >= STACKS || free_ptr >= DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        slot                         = free_ptr;
        free_ptr                     = entry_next[slot[IDX_W-1:0]];
        entry_next[slot[IDX_W-1:0]]  = top_of[sid];
        top_of[sid]                  = slot;
        entry_word[slot[IDX_W-1:0]]  = r.value;
      end
    end else begin
      if (sid >= STACKS || top_of[sid] >= DEPTH) begin
        res.status = STATUS_EMPTY;
      end else begin
        slot                         = top_of[sid];
        top_of[sid]                  = entry_next[slot[IDX_W-1:0]];
        entry_next[slot[IDX_W-1:0]]  = free_ptr;
        free_ptr                     = slot;
        res.popped_value             = entry_word[slot[IDX_W-1:0]];
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // Every entry starts chained into the free list, every stack empty.
      for (int i = 0; i < DEPTH; i++) begin
        entry_word[i] = '0;
        entry_next[i] = PTR_W'(i + 1);
      end
      for (int s = 0; s < STACKS; s++) begin
        top_of[s] = PTR_NULL;
      end
      free_ptr = '0;
      awaited_results.delete();
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // A result never answers a request accepted at the same edge, so the
      // output side is settled before the new expectation is queued.
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: status %0d, popped_value %0d",
                 out_data_i.status, out_data_i.popped_value);
          fails++;
        end else begin
          oldest = awaited_results.pop_front();
          if (out_data_i.status !== oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status, out_data_i.status);
            fails++;
          end
          if (out_data_i.popped_value !== oldest.popped_value) begin
            $error("popped_value: expected %0d, actual %0d",
                   oldest.popped_value, out_data_i.popped_value);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(serve_request(in_data_i));
      end
      fail_count_o <= fails;
      pending_o    <= awaited_results.size();
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for multi_stack_shared_store
// Runs a short directed sequence of pushes and pops, then long push-heavy,
// balanced and pop-heavy stretches that fill and drain the shared store,
// with random request gaps and result stalls in all but the last third.
// ----------------------------------------------------------------------------
module testbench;
  import msss_pkg::*;

  localparam int RUN_ITEMS   = 2100;
  localparam int STRETCH     = 300;
  localparam int SETTLE      = 20;
  localparam int CYCLE_LIMIT = 300000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  req_t in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  res_t out_data;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  multi_stack_shared_store u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  msss_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Offers one request after an optional random gap and returns once the
  // transaction has been taken.
  task automatic offer(input logic act, input logic [SID_W-1:0] sid,
                       input logic [31:0] word);
    req_t r;
    r.action   = act;
    r.stack_id = sid;
    r.value    = word;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int push_pct;
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 10;
    stall_pct     = 47;

    // Pops from empty stacks, the extreme words, and stacks unwound in turn.
    for (int s = 0; s < STACKS; s++) begin
      offer(ACT_POP, SID_W'(s), 32'h1234_5678);
    end
    offer(ACT_PUSH, 2'd0, 32'h7FFF_FFFF);
    offer(ACT_PUSH, 2'd1, 32'h8000_0000);
    offer(ACT_PUSH, 2'd2, 32'h0000_0000);
    offer(ACT_PUSH, 2'd3, 32'hFFFF_FFFF);
    offer(ACT_PUSH, 2'd0, 32'h5555_5555);
    offer(ACT_PUSH, 2'd0, 32'hAAAA_AAAA);
    repeat (4) offer(ACT_POP, 2'd0, 32'hFFFF_FFFF);
    offer(ACT_POP, 2'd1, 32'h0);
    offer(ACT_POP, 2'd2, 32'h0);
    offer(ACT_POP, 2'd3, 32'h0);
    offer(ACT_POP, 2'd3, 32'h0);
    offer(ACT_PUSH, 2'd2, 32'h0000_0001);
    offer(ACT_PUSH, 2'd1, 32'h0000_0002);
    offer(ACT_POP, 2'd2, 32'h0);
    offer(ACT_POP, 2'd1, 32'h0);

    // Push-heavy stretches overflow the store, pop-heavy ones empty it again.
    for (int seg = 0; seg < RUN_ITEMS / STRETCH; seg++) begin
      case (seg % 3)
        0:       push_pct = 97;
        1:       push_pct = 50;
        default: push_pct = 3;
      endcase
      drain();
      for (int k = 0; k < STRETCH; k++) begin
        n = seg * STRETCH + k;
        if (n < RUN_ITEMS / 3) begin
          send_idle_pct = 10;
          stall_pct     = 47;
        end else if (n < 2 * RUN_ITEMS / 3) begin
          send_idle_pct = 47;
          stall_pct     = 10;
        end else begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        offer(($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP,
              SID_W'($urandom_range(STACKS - 1)), $urandom());
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
